// File: rtl/core/ald_pkg.sv
// shared types, constants and codes for the array linked deque
// no dependencies
package ald_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int VALUE_BITS = 32;
    localparam int SLOT_BITS  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int COUNT_BITS = $clog2(SLOT_COUNT + 1);

    localparam int OP_BITS     = 3;
    localparam int PUSH_BITS   = 32;
    localparam int STATUS_BITS = 2;
    localparam int REMOVE_BITS = 32;

    localparam int IN_DATA_BITS  = ((PUSH_BITS + 7) / 8) * 8;
    localparam int IN_USER_BITS  = ((OP_BITS + 7) / 8) * 8;
    localparam int OUT_RAW_BITS  = SLOT_BITS + REMOVE_BITS + COUNT_BITS;
    localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;
    localparam int OUT_USER_BITS = ((STATUS_BITS + 7) / 8) * 8;

    localparam logic [OP_BITS-1:0] OP_PUSH_HEAD = 3'd0;
    localparam logic [OP_BITS-1:0] OP_PUSH_TAIL = 3'd1;
    localparam logic [OP_BITS-1:0] OP_POP_HEAD  = 3'd2;
    localparam logic [OP_BITS-1:0] OP_POP_TAIL  = 3'd3;
    localparam logic [OP_BITS-1:0] OP_CLEAR     = 3'd4;

    localparam logic [STATUS_BITS-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [SLOT_BITS-1:0]   slot_used;
        logic [REMOVE_BITS-1:0] removed_value;
        logic [COUNT_BITS-1:0]  entry_count;
    } result_t;

endpackage

// File: rtl/core/array_linked_deque_core.sv
// Double-ended queue of up to ald_pkg::SLOT_COUNT values held as a doubly
// linked list in a slot array. A command beat is captured in an input register
// when accepted, applied to the list by a single pass through the update logic
// once the result register can advance, and its result beat is then presented
// on the master side from that register; throughput is one beat per cycle while
// m_tready stays high. While a result beat waits on m_tready the input register
// can still take one command beat, after which s_tready drops; s_tready follows
// m_tready combinationally. Command codes ride on s_tuser, the status code on
// m_tuser. Depends on ald_pkg and ald_list.
module array_linked_deque_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // push_value [31:0]
    input  logic [ald_pkg::IN_DATA_BITS-1:0]  s_tdata,
    // operation [2:0]
    input  logic [ald_pkg::IN_USER_BITS-1:0]  s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // slot_used, removed_value, entry_count, from the lowest bit up
    output logic [ald_pkg::OUT_DATA_BITS-1:0] m_tdata,
    // status [1:0]
    output logic [ald_pkg::OUT_USER_BITS-1:0] m_tuser
);

    logic                            in_valid_reg;
    logic [ald_pkg::OP_BITS-1:0]     op_reg;
    logic [ald_pkg::PUSH_BITS-1:0]   value_reg;
    logic                            out_valid_reg;
    ald_pkg::result_t                result_reg;
    ald_pkg::result_t                result_next;
    logic                            advance;
    logic                            step;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    ald_list u_list (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .operation  (op_reg),
        .push_value (value_reg),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg    <= s_tuser[ald_pkg::OP_BITS-1:0];
            value_reg <= s_tdata[ald_pkg::PUSH_BITS-1:0];
        end
        if (step)
        begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = ald_pkg::OUT_DATA_BITS'({result_reg.entry_count,
                                               result_reg.removed_value,
                                               result_reg.slot_used});
    assign m_tuser  = ald_pkg::OUT_USER_BITS'(result_reg.status);

endmodule

// File: rtl/core/ald_free_find.sv
// lowest free slot search over the occupancy bits
// depends on ald_pkg
module ald_free_find (
    input  logic [ald_pkg::SLOT_COUNT-1:0] occupied,
    output logic [ald_pkg::SLOT_BITS-1:0]  free_slot
);

    always_comb
    begin
        free_slot = '0;
        for (int i = ald_pkg::SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!occupied[i])
            begin
                free_slot = ald_pkg::SLOT_BITS'(i);
            end
        end
    end

endmodule

// File: rtl/core/ald_list.sv
// slot array, links, head/tail pointers and the per-beat update logic
// depends on ald_pkg and ald_free_find
module ald_list (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [ald_pkg::OP_BITS-1:0]   operation,
    input  logic [ald_pkg::PUSH_BITS-1:0] push_value,
    output ald_pkg::result_t              result
);

    localparam int N  = ald_pkg::SLOT_COUNT;
    localparam int SB = ald_pkg::SLOT_BITS;
    localparam int CB = ald_pkg::COUNT_BITS;
    localparam int VB = ald_pkg::VALUE_BITS;

    logic [VB-1:0] value_reg     [N];
    logic [SB-1:0] to_head_reg   [N];
    logic [SB-1:0] to_tail_reg   [N];
    logic [VB-1:0] value_next    [N];
    logic [SB-1:0] to_head_next  [N];
    logic [SB-1:0] to_tail_next  [N];
    logic [N-1:0]  occupied_reg;
    logic [N-1:0]  occupied_next;
    logic [SB-1:0] head_reg;
    logic [SB-1:0] head_next;
    logic [SB-1:0] tail_reg;
    logic [SB-1:0] tail_next;
    logic [CB-1:0] count_reg;
    logic [CB-1:0] count_next;

    logic [SB-1:0] free_slot;
    logic [SB-1:0] pop_slot;
    logic [SB-1:0] neighbor;
    logic          is_full;
    logic          is_empty;

    ald_free_find u_free (
        .occupied  (occupied_reg),
        .free_slot (free_slot)
    );

    assign is_full  = (count_reg == CB'(N));
    assign is_empty = (count_reg == '0);

    always_comb
    begin
        value_next    = value_reg;
        to_head_next  = to_head_reg;
        to_tail_next  = to_tail_reg;
        occupied_next = occupied_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        result        = '0;
        pop_slot      = (operation == ald_pkg::OP_POP_HEAD) ? head_reg : tail_reg;
        neighbor      = (operation == ald_pkg::OP_POP_HEAD) ? to_tail_reg[pop_slot]
                                                             : to_head_reg[pop_slot];
        case (operation)
            ald_pkg::OP_PUSH_HEAD, ald_pkg::OP_PUSH_TAIL:
            begin
                if (is_full)
                begin
                    result.status = ald_pkg::ST_FULL;
                end
                else
                begin
                    value_next[free_slot]    = VB'($unsigned(push_value));
                    occupied_next[free_slot] = 1'b1;
                    if (is_empty)
                    begin
                        head_next               = free_slot;
                        tail_next               = free_slot;
                        to_head_next[free_slot] = free_slot;
                        to_tail_next[free_slot] = free_slot;
                    end
                    else if (operation == ald_pkg::OP_PUSH_HEAD)
                    begin
                        to_tail_next[free_slot] = head_reg;
                        to_head_next[free_slot] = free_slot;
                        to_head_next[head_reg]  = free_slot;
                        head_next               = free_slot;
                    end
                    else
                    begin
                        to_head_next[free_slot] = tail_reg;
                        to_tail_next[free_slot] = free_slot;
                        to_tail_next[tail_reg]  = free_slot;
                        tail_next               = free_slot;
                    end
                    count_next       = count_reg + CB'(1);
                    result.slot_used = free_slot;
                end
            end
            ald_pkg::OP_POP_HEAD, ald_pkg::OP_POP_TAIL:
            begin
                if (is_empty)
                begin
                    result.status = ald_pkg::ST_EMPTY;
                end
                else
                begin
                    result.removed_value    = ald_pkg::REMOVE_BITS'(value_reg[pop_slot]);
                    result.slot_used        = pop_slot;
                    occupied_next[pop_slot] = 1'b0;
                    count_next              = count_reg - CB'(1);
                    if (count_reg == CB'(1))
                    begin
                        head_next = '0;
                        tail_next = '0;
                    end
                    else if (operation == ald_pkg::OP_POP_HEAD)
                    begin
                        head_next              = neighbor;
                        to_head_next[neighbor] = neighbor;
                    end
                    else
                    begin
                        tail_next              = neighbor;
                        to_tail_next[neighbor] = neighbor;
                    end
                end
            end
            ald_pkg::OP_CLEAR:
            begin
                occupied_next = '0;
                head_next     = '0;
                tail_next     = '0;
                count_next    = '0;
            end
            default:
            begin
            end
        endcase
        result.entry_count = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occupied_reg <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
        end
        else if (step)
        begin
            occupied_reg <= occupied_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
        end
    end

    // slot payload and links, no reset
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            value_reg   <= value_next;
            to_head_reg <= to_head_next;
            to_tail_reg <= to_tail_next;
        end
    end

endmodule

// File: sim/tb_array_linked_deque_core.sv
`timescale 1ns / 1ps
// self-checking bench for array_linked_deque_core: random and directed command beats
// against an in-bench linked-slot predictor, with random stalls on both streams
// depends on ald_pkg and array_linked_deque_core
module tb_array_linked_deque_core;
    import ald_pkg::*;

    localparam logic [OP_BITS-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_BITS-1:0] OP_SPARE_MID   = 3'd6;
    localparam logic [OP_BITS-1:0] OP_SPARE_LAST  = 3'd7;
    localparam int RANDOM_CMDS  = 1700;
    localparam int CALM_TAIL    = 150;
    localparam int CYCLE_LIMIT  = 250000;
    localparam int SETTLE_TIME  = 8;

    typedef struct {
        logic [OP_BITS-1:0]   op;
        logic [PUSH_BITS-1:0] value;
        bit                   drain;
    } command_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata = '0;
    logic [IN_USER_BITS-1:0]  s_tuser = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic [OUT_USER_BITS-1:0] m_tuser;

    command_t pending_cmds[$];
    result_t  expected_results[$];
    int       fault_count = 0;
    int       cycle_count = 0;
    int       send_gap = 0;
    int       stall_gap = 0;
    bit       beat_taken = 1'b0;

    logic [PUSH_BITS-1:0] slot_data[SLOT_COUNT];
    logic [SLOT_BITS-1:0] link_head[SLOT_COUNT];
    logic [SLOT_BITS-1:0] link_tail[SLOT_COUNT];
    bit                   slot_busy[SLOT_COUNT];
    logic [SLOT_BITS-1:0] head_at = '0;
    logic [SLOT_BITS-1:0] tail_at = '0;
    int                   held = 0;

    array_linked_deque_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    function automatic result_t deque_apply(logic [OP_BITS-1:0] op,
                                            logic [PUSH_BITS-1:0] value);
        result_t r;
        logic [SLOT_BITS-1:0] s;
        r = '0;
        s = '0;
        case (op)
            OP_PUSH_HEAD, OP_PUSH_TAIL:
            begin
                if (held >= SLOT_COUNT)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    for (int i = SLOT_COUNT - 1; i >= 0; i--)
                        if (!slot_busy[i])
                            s = SLOT_BITS'(i);
                    slot_data[s] = value;
                    slot_busy[s] = 1'b1;
                    if (held == 0)
                    begin
                        head_at = s;
                        tail_at = s;
                        link_head[s] = s;
                        link_tail[s] = s;
                    end
                    else if (op == OP_PUSH_HEAD)
                    begin
                        link_tail[s] = head_at;
                        link_head[s] = s;
                        link_head[head_at] = s;
                        head_at = s;
                    end
                    else
                    begin
                        link_head[s] = tail_at;
                        link_tail[s] = s;
                        link_tail[tail_at] = s;
                        tail_at = s;
                    end
                    held++;
                    r.slot_used = s;
                end
            end
            OP_POP_HEAD, OP_POP_TAIL:
            begin
                if (held == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    s = (op == OP_POP_HEAD) ? head_at : tail_at;
                    r.removed_value = slot_data[s];
                    r.slot_used = s;
                    slot_busy[s] = 1'b0;
                    held--;
                    if (held == 0)
                    begin
                        head_at = '0;
                        tail_at = '0;
                    end
                    else if (op == OP_POP_HEAD)
                    begin
                        head_at = link_tail[s];
                        link_head[head_at] = head_at;
                    end
                    else
                    begin
                        tail_at = link_head[s];
                        link_tail[tail_at] = tail_at;
                    end
                end
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < SLOT_COUNT; i++)
                    slot_busy[i] = 1'b0;
                head_at = '0;
                tail_at = '0;
                held = 0;
            end
            default:
            begin
            end
        endcase
        r.entry_count = COUNT_BITS'(held);
        return r;
    endfunction

    task automatic queue_cmd(logic [OP_BITS-1:0] op, logic [PUSH_BITS-1:0] value, bit drain);
        command_t c;
        c.op = op;
        c.value = value;
        c.drain = drain;
        pending_cmds.push_back(c);
    endtask

    function automatic logic [PUSH_BITS-1:0] pick_value();
        case ($urandom_range(0, 11))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // driver
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || beat_taken))
        begin
            if (send_gap > 0)
            begin
                s_tvalid <= 1'b0;
                send_gap--;
            end
            else if (pending_cmds.size() != 0 &&
                     !(pending_cmds[0].drain && expected_results.size() != 0))
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= IN_DATA_BITS'(pending_cmds[0].value);
                s_tuser  <= IN_USER_BITS'(pending_cmds[0].op);
                void'(pending_cmds.pop_front());
                if (pending_cmds.size() > CALM_TAIL && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 12);
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result sink backpressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_gap > 0)
            begin
                m_tready <= 1'b0;
                stall_gap--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (pending_cmds.size() > CALM_TAIL && $urandom_range(0, 5) == 0)
                    stall_gap = $urandom_range(1, 12);
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        beat_taken = rst_n && s_tvalid && s_tready;
        if (beat_taken)
            expected_results.push_back(deque_apply(s_tuser[OP_BITS-1:0],
                                                   s_tdata[PUSH_BITS-1:0]));
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status        = m_tuser[STATUS_BITS-1:0];
            got.slot_used     = m_tdata[SLOT_BITS-1:0];
            got.removed_value = m_tdata[SLOT_BITS +: REMOVE_BITS];
            got.entry_count   = m_tdata[SLOT_BITS + REMOVE_BITS +: COUNT_BITS];
            if (expected_results.size() == 0)
            begin
                $error("result beat with nothing expected: status %0d slot %0d",
                       got.status, got.slot_used);
                fault_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, got.status);
                    fault_count++;
                end
                if (got.slot_used !== want.slot_used)
                begin
                    $error("slot_used expected %0d actual %0d", want.slot_used, got.slot_used);
                    fault_count++;
                end
                if (got.removed_value !== want.removed_value)
                begin
                    $error("removed_value expected %0h actual %0h",
                           want.removed_value, got.removed_value);
                    fault_count++;
                end
                if (got.entry_count !== want.entry_count)
                begin
                    $error("entry_count expected %0d actual %0d",
                           want.entry_count, got.entry_count);
                    fault_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        int made;
        int mode;
        int span;
        int roll;
        int push_odds;
        logic [OP_BITS-1:0] op;

        for (int i = 0; i < SLOT_COUNT; i++)
            slot_busy[i] = 1'b0;

        // empty pops, value extremes, spare codes, last-entry pop, clear
        queue_cmd(OP_POP_HEAD, 32'h1234_5678, 1'b0);
        queue_cmd(OP_POP_TAIL, 32'hffff_ffff, 1'b0);
        queue_cmd(OP_PUSH_HEAD, 32'h8000_0000, 1'b0);
        queue_cmd(OP_PUSH_TAIL, 32'h7fff_ffff, 1'b0);
        queue_cmd(OP_PUSH_HEAD, 32'h0000_0000, 1'b0);
        queue_cmd(OP_PUSH_TAIL, 32'hffff_ffff, 1'b0);
        queue_cmd(OP_SPARE_FIRST, $urandom, 1'b0);
        queue_cmd(OP_SPARE_MID, $urandom, 1'b0);
        queue_cmd(OP_SPARE_LAST, $urandom, 1'b0);
        queue_cmd(OP_POP_TAIL, '0, 1'b0);
        queue_cmd(OP_POP_HEAD, '0, 1'b0);
        queue_cmd(OP_POP_HEAD, '0, 1'b0);
        queue_cmd(OP_POP_TAIL, '0, 1'b0);
        queue_cmd(OP_POP_TAIL, '0, 1'b0);
        queue_cmd(OP_PUSH_TAIL, 32'h5555_aaaa, 1'b0);
        queue_cmd(OP_CLEAR, $urandom, 1'b0);
        queue_cmd(OP_PUSH_HEAD, 32'haaaa_5555, 1'b0);
        queue_cmd(OP_POP_HEAD, '0, 1'b0);

        // random episodes biased toward filling, draining or churning
        made = 0;
        while (made < RANDOM_CMDS)
        begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(10, 40);
            push_odds = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
            for (int k = 0; k < span; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    op = OP_CLEAR;
                else if (roll < 5)
                    op = OP_BITS'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
                else if ($urandom_range(0, 99) < push_odds)
                    op = $urandom_range(0, 1) ? OP_PUSH_HEAD : OP_PUSH_TAIL;
                else
                    op = $urandom_range(0, 1) ? OP_POP_HEAD : OP_POP_TAIL;
                queue_cmd(op, pick_value(),
                          (made == 0) || (k == 0 && $urandom_range(0, 3) == 0));
                if (op < OP_SPARE_FIRST)
                    made++;
            end
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_cmds.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TIME) @(posedge clk);

        if (fault_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: files.f
rtl/core/ald_pkg.sv
rtl/core/ald_free_find.sv
rtl/core/ald_list.sv
rtl/core/array_linked_deque_core.sv
sim/tb_array_linked_deque_core.sv
